// ===== sv/sincos_polynomial_four_lane_top_macros.svh =====
// Assertion macros used by the port-level checker of the sine and cosine pipeline.
`ifndef SINCOS_POLYNOMIAL_FOUR_LANE_TOP_MACROS_SVH
`define SINCOS_POLYNOMIAL_FOUR_LANE_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define SINCOS4_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define SINCOS4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sincos4_pkg.sv =====
// Shared types, constants and arithmetic helpers for the four-lane sine and cosine block.
`timescale 1ns / 1ps

package sincos4_pkg;

  // Lane counts.
  localparam int FIELD_LANES = 4;
  localparam int LANES_DEF   = 4;

  // Pipeline depth: range fold and square, five Horner steps, final scale.
  localparam int NSTG = 7;

  // Widths.
  localparam int ANG_W = 16;
  localparam int RES_W = 16;
  localparam int X_W   = 15;
  localparam int X2_W  = 32;
  localparam int ACC_W = 32;
  localparam int SAT_W = 19;

  // Rounding shifts.
  localparam int HORN_SH = 30;
  localparam int SIN_SH  = 29;
  localparam int COS_SH  = 16;

  // Angle limits in Q2.13.
  localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;

  // Output limit in Q1.14.
  localparam logic signed [SAT_W-1:0] OUT_MAX = 19'sd16384;

  // Horner coefficients in Q30, highest order first; the last entry is one.
  localparam logic signed [ACC_W-1:0] SIN_C [6] = '{
    -32'sd26, 32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
  };
  localparam logic signed [ACC_W-1:0] COS_C [6] = '{
    -32'sd280, 32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
  };

  // Input item: one angle per lane.
  typedef struct packed {
    logic signed [ANG_W-1:0] angle_0;
    logic signed [ANG_W-1:0] angle_1;
    logic signed [ANG_W-1:0] angle_2;
    logic signed [ANG_W-1:0] angle_3;
  } sincos4_in_t;

  // Result item: sine and cosine per lane.
  typedef struct packed {
    logic signed [RES_W-1:0] sine_0;
    logic signed [RES_W-1:0] sine_1;
    logic signed [RES_W-1:0] sine_2;
    logic signed [RES_W-1:0] sine_3;
    logic signed [RES_W-1:0] cosine_0;
    logic signed [RES_W-1:0] cosine_1;
    logic signed [RES_W-1:0] cosine_2;
    logic signed [RES_W-1:0] cosine_3;
  } sincos4_out_t;

  // One Horner step: round(r * x2 / 2^30) + k, rounding half up.
  function automatic logic signed [ACC_W-1:0] horner_step(
    input logic signed [ACC_W-1:0] r,
    input logic        [X2_W-1:0]  x2,
    input logic signed [ACC_W-1:0] k
  );
    logic signed [ACC_W+X2_W+1:0] prod;
    logic signed [ACC_W+X2_W+1:0] rnd;
    prod = (ACC_W+X2_W+2)'(r) * $signed({2'b00, x2});
    rnd  = (prod + (ACC_W+X2_W+2)'(2**(HORN_SH-1))) >>> HORN_SH;
    return $signed(rnd[ACC_W-1:0]) + k;
  endfunction

  // Clip a result to plus or minus one in Q1.14.
  function automatic logic signed [RES_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    if (v > OUT_MAX) begin
      c = OUT_MAX;
    end else if (v < -OUT_MAX) begin
      c = -OUT_MAX;
    end else begin
      c = v;
    end
    return c[RES_W-1:0];
  endfunction

endpackage

// ===== sv/sincos4_lane.sv =====
// Datapath of one lane: range fold, square, Horner pipeline and output scaling.
`timescale 1ns / 1ps

module sincos4_lane import sincos4_pkg::*; (
  input  logic                    clk,
  input  logic [NSTG-1:0]         en,
  input  logic signed [ANG_W-1:0] angle,
  output logic signed [RES_W-1:0] sine,
  output logic signed [RES_W-1:0] cosine
);

  // Stage 0 logic.
  logic signed [ANG_W-1:0]   clamp_c;
  logic signed [ANG_W-1:0]   red_c;
  logic                      flip_c;
  logic signed [X_W-1:0]     xr_c;
  logic signed [2*X_W-1:0]   sq_c;
  logic        [X2_W-1:0]    x2_c;

  // Pipeline registers.
  logic signed [X_W-1:0]     x_r    [0:NSTG-2];
  logic                      flip_r [0:NSTG-2];
  logic        [X2_W-1:0]    x2_r   [0:NSTG-3];
  logic signed [ACC_W-1:0]   sacc_r [1:NSTG-2];
  logic signed [ACC_W-1:0]   cacc_r [1:NSTG-2];
  logic signed [ACC_W-1:0]   sin_in [1:NSTG-2];
  logic signed [ACC_W-1:0]   cos_in [1:NSTG-2];

  // Final stage logic.
  logic signed [ACC_W+X_W-1:0] sprod_c;
  logic signed [ACC_W+X_W-1:0] ssh_c;
  logic signed [ACC_W-1:0]     csh_c;
  logic signed [SAT_W-1:0]     sval_c;
  logic signed [SAT_W-2:0]     cval_c;
  logic signed [SAT_W-2:0]     cneg_c;
  logic signed [RES_W-1:0]     sine_r;
  logic signed [RES_W-1:0]     cosine_r;

  // Clamp to plus or minus pi, then fold angles beyond pi/2 back toward zero.
  always_comb begin
    clamp_c = angle;
    if (angle > ANG_PI) begin
      clamp_c = ANG_PI;
    end else if (angle < -ANG_PI) begin
      clamp_c = -ANG_PI;
    end
    red_c  = clamp_c;
    flip_c = 1'b0;
    if (clamp_c > ANG_HALF_PI) begin
      red_c  = ANG_PI - clamp_c;
      flip_c = 1'b1;
    end else if (clamp_c < -ANG_HALF_PI) begin
      red_c  = -ANG_PI - clamp_c;
      flip_c = 1'b1;
    end
    xr_c = red_c[X_W-1:0];
    sq_c = xr_c * xr_c;
    x2_c = {sq_c[X2_W-5:0], 4'b0000};
  end

  // Accumulator inputs of each Horner stage; the first stage starts from the highest-order term.
  always_comb begin
    sin_in[1] = SIN_C[0];
    cos_in[1] = COS_C[0];
    for (int s = 2; s <= NSTG-2; s++) begin
      sin_in[s] = sacc_r[s-1];
      cos_in[s] = cacc_r[s-1];
    end
  end

  // Sine: polynomial times x, scaled from Q43 to Q14.
  // Cosine: polynomial scaled from Q30 to Q14, negated for folded angles.
  always_comb begin
    sprod_c = sacc_r[NSTG-2] * x_r[NSTG-2];
    ssh_c   = (sprod_c + (ACC_W+X_W)'(2**(SIN_SH-1))) >>> SIN_SH;
    sval_c  = ssh_c[SAT_W-1:0];
    csh_c   = (cacc_r[NSTG-2] + ACC_W'(2**(COS_SH-1))) >>> COS_SH;
    cval_c  = csh_c[SAT_W-2:0];
    cneg_c  = flip_r[NSTG-2] ? -cval_c : cval_c;
  end

  // Pipeline registers, each stage loading when its enable is high.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= xr_c;
      flip_r[0] <= flip_c;
      x2_r[0]   <= x2_c;
    end
    for (int s = 1; s <= NSTG-2; s++) begin
      if (en[s]) begin
        sacc_r[s] <= horner_step(sin_in[s], x2_r[s-1], SIN_C[s]);
        cacc_r[s] <= horner_step(cos_in[s], x2_r[s-1], COS_C[s]);
        x_r[s]    <= x_r[s-1];
        flip_r[s] <= flip_r[s-1];
      end
    end
    for (int s = 1; s <= NSTG-3; s++) begin
      if (en[s]) begin
        x2_r[s] <= x2_r[s-1];
      end
    end
    if (en[NSTG-1]) begin
      sine_r   <= sat_out(sval_c);
      cosine_r <= sat_out(SAT_W'(cneg_c));
    end
  end

  assign sine   = sine_r;
  assign cosine = cosine_r;

endmodule

// ===== sv/sincos_polynomial_four_lane_top.sv =====
// An accepted item passes through the fold and square stage, the Horner stages and the final scale stage.
// Throughput: one item per cycle; every stage holds one item and loads only
// when it is empty or its successor moves, so bubbles close up under a stall.
// The rate is set by the seven-stage lane pipeline, at most one multiply per
// polynomial in each stage.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module sincos_polynomial_four_lane_top import sincos4_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sincos4_in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sincos4_out_t out_data
);

  logic [NSTG-1:0]         v_r;
  logic [NSTG-1:0]         v_nxt;
  logic [NSTG-1:0]         rdy;
  logic signed [ANG_W-1:0] ang    [FIELD_LANES];
  logic signed [RES_W-1:0] sine   [FIELD_LANES];
  logic signed [RES_W-1:0] cosine [FIELD_LANES];

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    rdy[NSTG-1] = out_ready || !v_r[NSTG-1];
    for (int i = NSTG-2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Spread the input item over the lanes.
  assign ang[0] = in_data.angle_0;
  assign ang[1] = in_data.angle_1;
  assign ang[2] = in_data.angle_2;
  assign ang[3] = in_data.angle_3;

  // One datapath per active lane; unused lanes read as zero.
  for (genvar l = 0; l < FIELD_LANES; l++) begin : g_lane
    if (l < LANES) begin : g_on
      sincos4_lane u_lane (
        .clk    (clk),
        .en     (rdy),
        .angle  (ang[l]),
        .sine   (sine[l]),
        .cosine (cosine[l])
      );
    end else begin : g_off
      assign sine[l]   = '0;
      assign cosine[l] = '0;
    end
  end

  // Gather the result item.
  assign out_data.sine_0   = sine[0];
  assign out_data.sine_1   = sine[1];
  assign out_data.sine_2   = sine[2];
  assign out_data.sine_3   = sine[3];
  assign out_data.cosine_0 = cosine[0];
  assign out_data.cosine_1 = cosine[1];
  assign out_data.cosine_2 = cosine[2];
  assign out_data.cosine_3 = cosine[3];

  assign out_valid = v_r[NSTG-1];
  assign in_ready  = rdy[0];

endmodule

// ===== sv/sincos4_checker.sv =====
// Port-level checker for the four-lane sine and cosine block, with its bind.
`timescale 1ns / 1ps
`include "sincos_polynomial_four_lane_top_macros.svh"

module sincos4_checker import sincos4_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input sincos4_out_t out_data
);

  // A result item held back by the sink keeps its value.
  `SINCOS4_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "result item changed while stalled")

  // Reset empties the pipeline.
  `SINCOS4_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

  // The input side only stalls when a full pipeline is blocked at the output.
  `SINCOS4_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

  // Lane 0 results stay within plus or minus one.
  `SINCOS4_ASSERT(a_range, clk, rst_n, out_valid |-> (out_data.sine_0 <= 16'sd16384) && (out_data.sine_0 >= -16'sd16384) && (out_data.cosine_0 <= 16'sd16384) && (out_data.cosine_0 >= -16'sd16384), "lane 0 result out of range")

endmodule

bind sincos_polynomial_four_lane_top sincos4_checker u_sincos4_checker (.*);

// ===== tb/sv/sincos4_result_checker.sv =====
// Result checker for the four-lane sine and cosine block: predicts each result and compares it.
`timescale 1ns / 1ps

module sincos4_result_checker import sincos4_pkg::*; #(
  parameter int LANE_COUNT = LANES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  sincos4_in_t  in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  sincos4_out_t out_data,
  output int           mismatch_count,
  output int           pending_count,
  output int           checked_count
);

  localparam int     NUM_FIELDS   = 2 * FIELD_LANES;
  localparam int     REPORT_LIMIT = 10;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint UNIT_Q14     = 64'sd16384;
  localparam longint PI_Q13       = 64'sd25736;
  localparam longint HALF_PI_Q13  = 64'sd12868;

  // Polynomial terms in Q30, highest power of x squared first.
  longint sine_terms   [5] = '{-26, 2956, -213040, 8947846, -178956974};
  longint cosine_terms [5] = '{-280, 26586, -1491253, 44739212, -536870912};

  string field_names [NUM_FIELDS] = '{"sine_0", "sine_1", "sine_2", "sine_3",
                                      "cosine_0", "cosine_1", "cosine_2", "cosine_3"};

  sincos4_out_t pending_sincos [$];
  int           errors;
  int           checked;

  initial begin
    errors  = 0;
    checked = 0;
  end

  // Round half up: floor((v + 2^(sh-1)) / 2^sh).
  function automatic longint round_down_shift(input longint v, input int sh);
    longint q;
    q = v + (longint'(1) <<< (sh - 1));
    return q >>> sh;
  endfunction

  // Horner evaluation in x squared; the result is 1 + x^2 * P(x^2) in Q30.
  function automatic longint eval_poly(input bit use_cosine, input longint x2);
    longint acc;
    acc = use_cosine ? cosine_terms[0] : sine_terms[0];
    for (int i = 1; i < 5; i++) begin
      acc = round_down_shift(acc * x2, 30) + (use_cosine ? cosine_terms[i] : sine_terms[i]);
    end
    return round_down_shift(acc * x2, 30) + ONE_Q30;
  endfunction

  // Clip to plus or minus one in Q1.14.
  function automatic logic [RES_W-1:0] clip_unit(input longint v);
    longint c;
    c = v;
    if (c > UNIT_Q14) c = UNIT_Q14;
    if (c < -UNIT_Q14) c = -UNIT_Q14;
    return c[RES_W-1:0];
  endfunction

  // Field i of a result, with sine_0 as field 0.
  function automatic logic [RES_W-1:0] field_of(input sincos4_out_t v, input int i);
    return v[(NUM_FIELDS - 1 - i) * RES_W +: RES_W];
  endfunction

  // Expected sine and cosine of all lanes for one angle item.
  function automatic sincos4_out_t predict_sincos(input sincos4_in_t item);
    sincos4_out_t               res;
    logic signed [ANG_W-1:0]    angs [FIELD_LANES];
    longint                     x;
    longint                     x2;
    longint                     p;
    bit                         flip;
    res  = '0;
    angs = '{item.angle_0, item.angle_1, item.angle_2, item.angle_3};
    for (int ln = 0; ln < FIELD_LANES; ln++) begin
      if (ln < LANE_COUNT) begin
        x    = angs[ln];
        flip = 1'b0;
        if (x > PI_Q13) x = PI_Q13;
        if (x < -PI_Q13) x = -PI_Q13;
        // Fold the outer quadrants back toward zero; cosine changes sign there.
        if (x > HALF_PI_Q13) begin
          x    = PI_Q13 - x;
          flip = 1'b1;
        end else if (x < -HALF_PI_Q13) begin
          x    = -PI_Q13 - x;
          flip = 1'b1;
        end
        x2 = x * x * 16;
        p  = eval_poly(1'b0, x2);
        res[(NUM_FIELDS - 1 - ln) * RES_W +: RES_W] = clip_unit(round_down_shift(p * x, 29));
        p  = round_down_shift(eval_poly(1'b1, x2), 16);
        res[(FIELD_LANES - 1 - ln) * RES_W +: RES_W] = clip_unit(flip ? -p : p);
      end
    end
    return res;
  endfunction

  // Compare one result with the oldest expectation, field by field.
  task automatic check_result(input sincos4_out_t got);
    sincos4_out_t want;
    if (pending_sincos.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("[%0t] unexpected result item %h with nothing pending", $realtime, got);
      end
    end else begin
      want = pending_sincos.pop_front();
      checked++;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (field_of(got, i) !== field_of(want, i)) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("[%0t] result %0d %s: expected %0d, got %0d", $realtime, checked,
                     field_names[i], $signed(field_of(want, i)), $signed(field_of(got, i)));
          end
        end
      end
    end
  endtask

  // Watch both channels; inputs are queued before outputs are checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      pending_sincos.delete();
    end else begin
      if (in_valid && in_ready) pending_sincos.push_back(predict_sincos(in_data));
      if (out_valid && out_ready) check_result(out_data);
    end
    mismatch_count <= errors;
    pending_count  <= pending_sincos.size();
    checked_count  <= checked;
  end

endmodule

// ===== tb/sv/tb_sincos_polynomial_four_lane_top.sv =====
// Testbench top for the four-lane sine and cosine block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sincos_polynomial_four_lane_top;
  import sincos4_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_LIMIT  = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  sincos4_in_t  in_data;
  logic         out_valid;
  logic         out_ready;
  sincos4_out_t out_data;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int sent_count;
  int directed_count;
  bit hold_active;
  bit hold_done;

  sincos_polynomial_four_lane_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sincos4_result_checker #(.LANE_COUNT(LANES_DEF)) u_result_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_angles(input sincos4_in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Drop valid for a number of cycles; no gaps while the receiver holds off.
  task automatic pause_sender(input int cycles);
    if (cycles > 0 && !hold_active) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Random angle: mostly in range, some near pi/2 and pi, some anywhere in 16 bits.
  function automatic logic signed [ANG_W-1:0] rand_angle();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 65535) - 32768;
      1:       v = int'(ANG_HALF_PI) + $urandom_range(0, 8) - 4;
      2:       v = int'(ANG_PI) + $urandom_range(0, 8) - 4;
      default: v = $urandom_range(0, 2 * int'(ANG_PI)) - int'(ANG_PI);
    endcase
    if (v[15] == 1'b0 && $urandom_range(0, 1) && (v == int'(ANG_HALF_PI) + v - int'(ANG_HALF_PI))
        && $urandom_range(0, 3) == 0) begin
      v = -v;
    end
    return v[ANG_W-1:0];
  endfunction

  // Receiver: a random flow-control mode that changes each time the phase counter wraps, plus one long hold-off.
  initial begin
    int          mode;
    int          phase;
    int          hold_left;
    logic [15:0] pattern;
    out_ready   <= 1'b0;
    hold_active  = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    phase        = 0;
    mode         = 0;
    pattern      = 16'hB3C5;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_left   = HOLD_CYCLES;
        hold_done   = 1'b1;
        hold_active = 1'b1;
      end
      if (phase == 0) mode = $urandom_range(0, 3);
      phase = (phase + 1) % 64;
      pattern = {pattern[14:0], pattern[15]};
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_active = 1'b0;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= pattern[0];
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic signed [ANG_W-1:0] edge_angles [6][FIELD_LANES];
    logic signed [ANG_W-1:0] lanes [FIELD_LANES];
    sincos4_in_t             item;
    int                      burst;
    int                      waited;

    // Extremes, fold points, out-of-range angles and a few familiar angles.
    edge_angles = '{
      '{16'sd0, ANG_PI, -ANG_PI, ANG_HALF_PI},
      '{-ANG_HALF_PI, ANG_HALF_PI + 16'sd1, -ANG_HALF_PI - 16'sd1, 16'sd1},
      '{-16'sd1, ANG_PI + 16'sd1, -ANG_PI - 16'sd1, 16'sd32767},
      '{-16'sd32768, ANG_PI - 16'sd1, -ANG_PI + 16'sd1, ANG_HALF_PI - 16'sd1},
      '{-ANG_HALF_PI + 16'sd1, 16'sd8192, -16'sd8192, 16'sd4289},
      '{16'sh5555, 16'shAAAA, 16'sd6434, -16'sd19302}
    };

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    sent_count     = 0;
    directed_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every case once in every lane position.
    for (int rot = 0; rot < FIELD_LANES; rot++) begin
      for (int d = 0; d < 6; d++) begin
        for (int ln = 0; ln < FIELD_LANES; ln++) begin
          lanes[ln] = edge_angles[d][(ln + rot) % FIELD_LANES];
        end
        item = '{lanes[0], lanes[1], lanes[2], lanes[3]};
        send_angles(item);
        directed_count++;
        pause_sender($urandom_range(0, 2));
      end
    end

    // Random part in bursts with random gaps; some gaps are zero.
    while (sent_count < directed_count + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        item = '{rand_angle(), rand_angle(), rand_angle(), rand_angle()};
        send_angles(item);
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline depth and a margin. The pending count
    // is a registered copy of the result checker's queue size.
    waited = 0;
    @(posedge clk);
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (NSTG + 5) @(posedge clk);

    $display("Run covered %0d angle items (%0d directed, rest random) and checked %0d results.",
             sent_count, directed_count, checked_count);
    $display("Long receiver hold-off done: %0d; field mismatches: %0d; results left waiting: %0d.",
             hold_done, mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("Timeout: the run did not finish.");
    $display("TEST FAILED");
    $finish;
  end

endmodule
